/* rtl/caf_pkg.sv */
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the ALU with flags
// Operation codes, result selects, beat payloads and stage payloads.
// ----------------------------------------------------------------------------
package caf_pkg;

  // Operation codes carried in req_type.
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_ADC    = 4'd1,
    OP_AND    = 4'd2,
    OP_CP     = 4'd3,
    OP_INC    = 4'd4,
    OP_DEC    = 4'd5,
    OP_DAA    = 4'd6,
    OP_CPL    = 4'd7,
    OP_CCF    = 4'd8,
    OP_ADD16  = 4'd9,
    OP_ADD_SP = 4'd10
  } op_e;

  // How the last stage forms the value and flags.
  typedef enum logic [2:0] {
    SEL_LOGIC,
    SEL_ADD8,
    SEL_CP,
    SEL_INC,
    SEL_DEC,
    SEL_DAA,
    SEL_ADD16,
    SEL_ADD_SP
  } sel_e;

  // Flag bit positions.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
  localparam logic [7:0] BCD_BYTE_MAX  = 8'h99;
  localparam logic [7:0] ADJ_LOW       = 8'h06;
  localparam logic [7:0] ADJ_HIGH      = 8'h60;
  localparam logic [7:0] BYTE_ONES     = 8'hFF;

  // Input beat.
  typedef struct packed {
    logic [3:0]  req_type;
    logic [15:0] left_operand;
    logic [15:0] right_operand;
    logic [3:0]  flags_in;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
  } rsp_t;

  // Decoded operands for the shared adder.
  typedef struct packed {
    sel_e        sel;
    logic [15:0] x;
    logic [15:0] y;
    logic        cin;
    logic [15:0] lval;
    logic [3:0]  lflags;
    logic        daa_c;
    logic [3:0]  flags;
  } s1_t;

  // Low byte of the sum and its carries.
  typedef struct packed {
    sel_e        sel;
    logic [7:0]  x_hi;
    logic [7:0]  y_hi;
    logic [7:0]  x_lo;
    logic [7:0]  low;
    logic        c4;
    logic        c8;
    logic [15:0] lval;
    logic [3:0]  lflags;
    logic        daa_c;
    logic [3:0]  flags;
  } s2_t;

endpackage

/* rtl/caf_decode.sv */
// ----------------------------------------------------------------------------
// caf_decode: first pipeline stage
// Decodes the operation, prepares adder operands and logic results.
// ----------------------------------------------------------------------------
module caf_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  caf_pkg::req_t in_data,
  output logic          out_valid,
  output caf_pkg::s1_t  out_data
);
  import caf_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] adj;
  logic       zi;
  logic       ni;
  logic       hi;
  logic       ci;
  logic       adj_lo;
  logic       adj_hi;
  logic [7:0] and_val;
  s1_t        out_data_next;

  assign a       = in_data.left_operand[7:0];
  assign b       = in_data.right_operand[7:0];
  assign zi      = in_data.flags_in[FLAG_Z];
  assign ni      = in_data.flags_in[FLAG_N];
  assign hi      = in_data.flags_in[FLAG_H];
  assign ci      = in_data.flags_in[FLAG_C];
  assign and_val = a & b;

  // Decimal adjust amount: after a subtraction only the stored flags count.
  always_comb begin
    if (ni) begin
      adj_lo = hi;
      adj_hi = ci;
    end else begin
      adj_lo = hi || (a[3:0] > BCD_DIGIT_MAX);
      adj_hi = ci || (a > BCD_BYTE_MAX);
    end
    adj = (adj_lo ? ADJ_LOW : 8'h00) | (adj_hi ? ADJ_HIGH : 8'h00);
  end

  // Operand selection for the shared adder.
  always_comb begin
    out_data_next        = '0;
    out_data_next.sel    = SEL_LOGIC;
    out_data_next.x      = in_data.left_operand;
    out_data_next.y      = 16'h0000;
    out_data_next.cin    = 1'b0;
    out_data_next.lval   = in_data.left_operand;
    out_data_next.lflags = in_data.flags_in;
    out_data_next.daa_c  = 1'b0;
    out_data_next.flags  = in_data.flags_in;
    unique case (in_data.req_type)
      OP_ADD: begin
        out_data_next.sel = SEL_ADD8;
        out_data_next.x   = {8'h00, a};
        out_data_next.y   = {8'h00, b};
      end
      OP_ADC: begin
        out_data_next.sel = SEL_ADD8;
        out_data_next.x   = {8'h00, a};
        out_data_next.y   = {8'h00, b};
        out_data_next.cin = ci;
      end
      OP_AND: begin
        out_data_next.lval   = {8'h00, and_val};
        out_data_next.lflags = {and_val == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_CP: begin
        out_data_next.sel = SEL_CP;
        out_data_next.x   = {8'h00, a};
        out_data_next.y   = {8'h00, ~b};
        out_data_next.cin = 1'b1;
      end
      OP_INC: begin
        out_data_next.sel = SEL_INC;
        out_data_next.x   = {8'h00, a};
        out_data_next.cin = 1'b1;
      end
      OP_DEC: begin
        out_data_next.sel = SEL_DEC;
        out_data_next.x   = {8'h00, a};
        out_data_next.y   = {8'h00, BYTE_ONES};
      end
      OP_DAA: begin
        out_data_next.sel   = SEL_DAA;
        out_data_next.x     = {8'h00, a};
        out_data_next.y     = ni ? {8'h00, ~adj} : {8'h00, adj};
        out_data_next.cin   = ni;
        out_data_next.daa_c = ni ? ci : adj_hi;
      end
      OP_CPL: begin
        out_data_next.lval   = {8'h00, ~a};
        out_data_next.lflags = {zi, 1'b1, 1'b1, ci};
      end
      OP_CCF: begin
        out_data_next.lval   = {8'h00, a};
        out_data_next.lflags = {zi, 1'b0, 1'b0, ~ci};
      end
      OP_ADD16: begin
        out_data_next.sel = SEL_ADD16;
        out_data_next.y   = in_data.right_operand;
      end
      OP_ADD_SP: begin
        out_data_next.sel = SEL_ADD_SP;
        out_data_next.y   = {{8{b[7]}}, b};
      end
      default: begin
        out_data_next.sel = SEL_LOGIC;
      end
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* rtl/caf_low_add.sv */
// ----------------------------------------------------------------------------
// caf_low_add: second pipeline stage
// Adds the low byte in two nibbles and keeps both nibble carries.
// ----------------------------------------------------------------------------
module caf_low_add (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  caf_pkg::s1_t in_data,
  output logic         out_valid,
  output caf_pkg::s2_t out_data
);
  import caf_pkg::*;

  logic [4:0] nib0;
  logic [4:0] nib1;
  s2_t        out_data_next;

  // Two chained nibble adds give the half carry and the byte carry.
  assign nib0 = {1'b0, in_data.x[3:0]} + {1'b0, in_data.y[3:0]} + {4'h0, in_data.cin};
  assign nib1 = {1'b0, in_data.x[7:4]} + {1'b0, in_data.y[7:4]} + {4'h0, nib0[4]};

  always_comb begin
    out_data_next        = '0;
    out_data_next.sel    = in_data.sel;
    out_data_next.x_hi   = in_data.x[15:8];
    out_data_next.y_hi   = in_data.y[15:8];
    out_data_next.x_lo   = in_data.x[7:0];
    out_data_next.low    = {nib1[3:0], nib0[3:0]};
    out_data_next.c4     = nib0[4];
    out_data_next.c8     = nib1[4];
    out_data_next.lval   = in_data.lval;
    out_data_next.lflags = in_data.lflags;
    out_data_next.daa_c  = in_data.daa_c;
    out_data_next.flags  = in_data.flags;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* rtl/caf_finish.sv */
// ----------------------------------------------------------------------------
// caf_finish: third pipeline stage and output register
// Adds the high byte and forms the result value and flags.
// ----------------------------------------------------------------------------
module caf_finish (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  caf_pkg::s2_t  in_data,
  output logic          out_valid,
  output caf_pkg::rsp_t out_data
);
  import caf_pkg::*;

  logic [4:0] nib2;
  logic [4:0] nib3;
  logic [7:0] high;
  logic       c12;
  logic       c16;
  logic       zl;
  logic       zi;
  logic       ci;
  rsp_t       out_data_next;

  // High byte add, continuing from the low byte carry.
  assign nib2 = {1'b0, in_data.x_hi[3:0]} + {1'b0, in_data.y_hi[3:0]} + {4'h0, in_data.c8};
  assign nib3 = {1'b0, in_data.x_hi[7:4]} + {1'b0, in_data.y_hi[7:4]} + {4'h0, nib2[4]};
  assign high = {nib3[3:0], nib2[3:0]};
  assign c12  = nib2[4];
  assign c16  = nib3[4];
  assign zl   = (in_data.low == 8'h00);
  assign zi   = in_data.flags[FLAG_Z];
  assign ci   = in_data.flags[FLAG_C];

  // Result and flag selection.
  always_comb begin
    out_data_next = '0;
    unique case (in_data.sel)
      SEL_ADD8: begin
        out_data_next.result_value = {8'h00, in_data.low};
        out_data_next.flags_out    = {zl, 1'b0, in_data.c4, in_data.c8};
      end
      SEL_CP: begin
        out_data_next.result_value = {8'h00, in_data.x_lo};
        out_data_next.flags_out    = {zl, 1'b1, ~in_data.c4, ~in_data.c8};
      end
      SEL_INC: begin
        out_data_next.result_value = {8'h00, in_data.low};
        out_data_next.flags_out    = {zl, 1'b0, in_data.c4, ci};
      end
      SEL_DEC: begin
        out_data_next.result_value = {8'h00, in_data.low};
        out_data_next.flags_out    = {zl, 1'b1, ~in_data.c4, ci};
      end
      SEL_DAA: begin
        out_data_next.result_value = {8'h00, in_data.low};
        out_data_next.flags_out    = {zl, in_data.flags[FLAG_N], 1'b0, in_data.daa_c};
      end
      SEL_ADD16: begin
        out_data_next.result_value = {high, in_data.low};
        out_data_next.flags_out    = {zi, 1'b0, c12, c16};
      end
      SEL_ADD_SP: begin
        out_data_next.result_value = {high, in_data.low};
        out_data_next.flags_out    = {1'b0, 1'b0, in_data.c4, in_data.c8};
      end
      default: begin
        out_data_next.result_value = in_data.lval;
        out_data_next.flags_out    = in_data.lflags;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* rtl/cpu_alu_with_flags_top.sv */
// Path: decode, low byte add and output registers. Throughput: one beat per
// cycle while rsp_stall is low; each of the three stages advances on its own,
// so an empty stage is filled even while a finished result waits on rsp_stall.
// Reset: synchronous, active high; it clears the stage valid bits only.
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_top: 8-bit ALU with flags, three-stage pipeline
// Decode, low byte add and high byte add with result selection.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  caf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output caf_pkg::rsp_t rsp
);
  import caf_pkg::*;

  logic s1_valid;
  logic s2_valid;
  logic en1;
  logic en2;
  logic en3;
  s1_t  s1_data;
  s2_t  s2_data;

  // Each stage moves when it is empty or the stage after it moves.
  assign en3       = !rsp_valid || !rsp_stall;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign req_stall = !en1;

  caf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (en1),
    .in_valid  (req_valid),
    .in_data   (req),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  caf_low_add u_low_add (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  caf_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en3),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .out_valid (rsp_valid),
    .out_data  (rsp)
  );

`ifndef NO_ASSERTIONS
  // The input is only held off while the first stage holds a beat.
  a_stall_needs_full : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("input stalled with an empty first stage");

  // An accepted beat reaches the output register when the output is not held.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
    else $error("accepted beat did not reach the output");

  // With every stage full and the output held, nothing more is taken.
  a_full_backpressure : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && rsp_valid && rsp_stall) |-> req_stall)
    else $error("beat accepted into a full pipeline");

  // A bubble in the middle stage lets the first stage drain.
  a_bubble_collapse : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_valid) |=> s2_valid)
    else $error("first stage did not advance into an empty stage");
`endif

endmodule
